### rtl/epoch_seconds_to_calendar_core_assert.svh
// -----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core_assert.svh
// assertion macros for the checker file esc_checker
// -----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

// property checked at every rising edge, ignored while reset is high
`define ESC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ESC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/esc_pkg.sv
// -----------------------------------------------------------------------------
// esc_pkg
// types, constants and the month table of the epoch to calendar pipeline
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package esc_pkg;

   // seconds per day is 2^7 * 675
   localparam int unsigned DAY_SHIFT     = 7;
   localparam logic [23:0] DAY_ODD       = 24'd675;
   localparam logic [48:0] RECIP_DAY     = 49'd25451658;   // floor(2^34 / 675)
   localparam int unsigned RECIP_DAY_SH  = 34;

   localparam logic [25:0] RECIP_HOUR    = 26'd4661;       // ceil(2^20 / 225)
   localparam int unsigned RECIP_HOUR_SH = 20;
   localparam logic [16:0] SECS_HOUR     = 17'd3600;

   localparam logic [22:0] RECIP_MIN     = 23'd4370;       // ceil(2^16 / 15)
   localparam int unsigned RECIP_MIN_SH  = 16;
   localparam logic [11:0] SECS_MIN      = 12'd60;

   localparam logic [30:0] RECIP_WEEK    = 31'd37450;      // ceil(2^18 / 7)
   localparam int unsigned RECIP_WEEK_SH = 18;
   localparam logic [14:0] WEEK_DAYS     = 15'd7;
   localparam logic [14:0] FIRST_WEEKDAY = 15'd4;

   // days counted from 1968-01-01, the leap year opening a four year cycle
   localparam logic [30:0] RECIP_QUAD    = 31'd45934;      // ceil(2^26 / 1461)
   localparam int unsigned RECIP_QUAD_SH = 26;
   localparam logic [14:0] QUAD_DAYS     = 15'd1461;
   localparam logic [14:0] EPOCH_OFFSET  = 15'd731;
   localparam logic [10:0] BASE_YEAR     = 11'd1968;

   localparam logic [10:0] YEAR1_START   = 11'd366;
   localparam logic [10:0] YEAR2_START   = 11'd731;
   localparam logic [10:0] YEAR3_START   = 11'd1096;

   typedef struct packed {
      logic [14:0] days;
      logic [16:0] hms;
   } esc_split_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [11:0] rest;
      logic [2:0]  weekday;
      logic [4:0]  quad;
      logic [10:0] quad_rem;
   } esc_field_type;

   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } esc_date_type;

   // first day of month idx (0 = january) counted from the first of january
   function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
      logic [8:0] base;
      unique case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return (leap && (idx >= 4'd2)) ? base + 9'd1 : base;
   endfunction

endpackage

### rtl/esc_day_split.sv
// -----------------------------------------------------------------------------
// esc_day_split
// two stage split of epoch seconds into whole days and seconds of the day
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_day_split (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [30:0]           in_seconds,
   output logic                  out_valid,
   input  logic                  out_ready,
   output esc_pkg::esc_split_type out_data
);

   logic        va_ff;
   logic        vb_ff;
   logic        en_a;
   logic        en_b;
   logic [23:0] x_in;
   logic [48:0] prod_in;
   logic [23:0] x_ff;
   logic [6:0]  low_ff;
   logic [14:0] q0_ff;
   logic [23:0] rem_full;
   logic [10:0] rem;
   logic        fix;
   logic [10:0] rem_fix;
   esc_pkg::esc_split_type split_in;
   esc_pkg::esc_split_type split_ff;

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   // day estimate by reciprocal, low by at most one
   assign x_in    = in_seconds[30:esc_pkg::DAY_SHIFT];
   assign prod_in = 49'(x_in) * esc_pkg::RECIP_DAY;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en_a) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && in_valid) begin
         x_ff   <= x_in;
         low_ff <= in_seconds[esc_pkg::DAY_SHIFT-1:0];
         q0_ff  <= prod_in[esc_pkg::RECIP_DAY_SH +: 15];
      end
   end

   // correction step
   assign rem_full = x_ff - 24'(q0_ff) * esc_pkg::DAY_ODD;
   assign rem      = rem_full[10:0];
   assign fix      = (rem >= esc_pkg::DAY_ODD[10:0]);
   assign rem_fix  = fix ? rem - esc_pkg::DAY_ODD[10:0] : rem;

   always_comb begin
      split_in.days = q0_ff + 15'(fix);
      split_in.hms  = {rem_fix[9:0], low_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en_b) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && va_ff) begin
         split_ff <= split_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = split_ff;

endmodule

### rtl/esc_field_calc.sv
// -----------------------------------------------------------------------------
// esc_field_calc
// two stage hour, weekday and four year cycle extraction
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_field_calc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  esc_pkg::esc_split_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output esc_pkg::esc_field_type out_data
);

   logic        va_ff;
   logic        vb_ff;
   logic        en_a;
   logic        en_b;
   logic [25:0] hour_prod;
   logic [14:0] w_in;
   logic [14:0] d_in;
   logic [30:0] w_prod;
   logic [30:0] d_prod;
   logic [4:0]  hour_ff;
   logic [16:0] hms_ff;
   logic [14:0] w_ff;
   logic [11:0] wq_ff;
   logic [14:0] d_ff;
   logic [4:0]  quad_ff;
   logic [16:0] rest_full;
   logic [14:0] wd_full;
   logic [14:0] qr_full;
   esc_pkg::esc_field_type field_in;
   esc_pkg::esc_field_type field_ff;

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   assign hour_prod = 26'(in_data.hms[16:4]) * esc_pkg::RECIP_HOUR;
   assign w_in      = in_data.days + esc_pkg::FIRST_WEEKDAY;
   assign d_in      = in_data.days + esc_pkg::EPOCH_OFFSET;
   assign w_prod    = 31'(w_in) * esc_pkg::RECIP_WEEK;
   assign d_prod    = 31'(d_in) * esc_pkg::RECIP_QUAD;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en_a) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && in_valid) begin
         hour_ff <= hour_prod[esc_pkg::RECIP_HOUR_SH +: 5];
         hms_ff  <= in_data.hms;
         w_ff    <= w_in;
         wq_ff   <= w_prod[esc_pkg::RECIP_WEEK_SH +: 12];
         d_ff    <= d_in;
         quad_ff <= d_prod[esc_pkg::RECIP_QUAD_SH +: 5];
      end
   end

   // remainders
   assign rest_full = hms_ff - 17'(hour_ff) * esc_pkg::SECS_HOUR;
   assign wd_full   = w_ff - 15'(wq_ff) * esc_pkg::WEEK_DAYS;
   assign qr_full   = d_ff - 15'(quad_ff) * esc_pkg::QUAD_DAYS;

   always_comb begin
      field_in.hour     = hour_ff;
      field_in.rest     = rest_full[11:0];
      field_in.weekday  = wd_full[2:0];
      field_in.quad     = quad_ff;
      field_in.quad_rem = qr_full[10:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en_b) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && va_ff) begin
         field_ff <= field_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = field_ff;

endmodule

### rtl/esc_date_calc.sv
// -----------------------------------------------------------------------------
// esc_date_calc
// two stage minute, second, year, month and day of month resolution
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_date_calc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  esc_pkg::esc_field_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output esc_pkg::esc_date_type  out_data
);

   logic        va_ff;
   logic        vb_ff;
   logic        en_a;
   logic        en_b;
   logic [22:0] min_prod;
   logic [1:0]  yic;
   logic [10:0] ystart;
   logic [10:0] doy_full;
   logic [10:0] year_in;
   logic [5:0]  minute_ff;
   logic [11:0] rest_ff;
   logic [4:0]  hour_ff;
   logic [2:0]  weekday_ff;
   logic [10:0] year_ff;
   logic [8:0]  doy_ff;
   logic        leap_ff;
   logic [11:0] sec_full;
   logic [3:0]  midx;
   logic [8:0]  day_full;
   esc_pkg::esc_date_type date_in;
   esc_pkg::esc_date_type date_ff;

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   assign min_prod = 23'(in_data.rest[11:2]) * esc_pkg::RECIP_MIN;

   // year within the four year cycle, the first one being leap
   always_comb begin
      priority if (in_data.quad_rem >= esc_pkg::YEAR3_START) begin
         yic    = 2'd3;
         ystart = esc_pkg::YEAR3_START;
      end else if (in_data.quad_rem >= esc_pkg::YEAR2_START) begin
         yic    = 2'd2;
         ystart = esc_pkg::YEAR2_START;
      end else if (in_data.quad_rem >= esc_pkg::YEAR1_START) begin
         yic    = 2'd1;
         ystart = esc_pkg::YEAR1_START;
      end else begin
         yic    = 2'd0;
         ystart = 11'd0;
      end
   end

   assign doy_full = in_data.quad_rem - ystart;
   assign year_in  = esc_pkg::BASE_YEAR + {4'd0, in_data.quad, 2'd0} + 11'(yic);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en_a) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && in_valid) begin
         minute_ff  <= min_prod[esc_pkg::RECIP_MIN_SH +: 6];
         rest_ff    <= in_data.rest;
         hour_ff    <= in_data.hour;
         weekday_ff <= in_data.weekday;
         year_ff    <= year_in;
         doy_ff     <= doy_full[8:0];
         leap_ff    <= (yic == 2'd0);
      end
   end

   assign sec_full = rest_ff - 12'(minute_ff) * esc_pkg::SECS_MIN;

   // month index is the number of later month starts already reached
   always_comb begin
      midx = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (doy_ff >= esc_pkg::month_start(4'(k), leap_ff)) begin
            midx = midx + 4'd1;
         end
      end
   end

   assign day_full = doy_ff - esc_pkg::month_start(midx, leap_ff) + 9'd1;

   always_comb begin
      date_in.year         = year_ff;
      date_in.month        = midx + 4'd1;
      date_in.day_of_month = day_full[4:0];
      date_in.hour         = hour_ff;
      date_in.minute       = minute_ff;
      date_in.second       = sec_full[5:0];
      date_in.weekday      = weekday_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en_b) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && va_ff) begin
         date_ff <= date_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = date_ff;

endmodule

### rtl/epoch_seconds_to_calendar_core.sv
// -----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// seconds since 1970-01-01 00:00:00 to calendar date, time and weekday
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_ready  req_epoch_seconds
//   rsp       out         rsp_valid/rsp_ready  rsp_year .. rsp_weekday
//
// one request per cycle sustained while the receiver keeps rsp_ready high
// six register stages in three sections, each stage with its own valid bit
// a stage loads when it is empty or the stage after it moves, so bubbles close up
// reset clears only the valid bits; payload registers carry no reset
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [30:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [2:0]  rsp_weekday
);

   logic                   split_valid;
   logic                   split_ready;
   esc_pkg::esc_split_type split_data;
   logic                   field_valid;
   logic                   field_ready;
   esc_pkg::esc_field_type field_data;
   esc_pkg::esc_date_type  date_data;

   esc_day_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_seconds (req_epoch_seconds),
      .out_valid  (split_valid),
      .out_ready  (split_ready),
      .out_data   (split_data)
   );

   esc_field_calc u_field (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (field_valid),
      .out_ready (field_ready),
      .out_data  (field_data)
   );

   esc_date_calc u_date (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (field_valid),
      .in_ready  (field_ready),
      .in_data   (field_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (date_data)
   );

   assign rsp_year         = date_data.year;
   assign rsp_month        = date_data.month;
   assign rsp_day_of_month = date_data.day_of_month;
   assign rsp_hour         = date_data.hour;
   assign rsp_minute       = date_data.minute;
   assign rsp_second       = date_data.second;
   assign rsp_weekday      = date_data.weekday;

endmodule

### rtl/esc_checker.sv
// -----------------------------------------------------------------------------
// esc_checker
// port level checks of the epoch to calendar core, bound to the top level
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_core_assert.svh"

module esc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [30:0] req_epoch_seconds,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day_of_month,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second,
   input logic [2:0]  rsp_weekday
);

   logic        req_wait;
   logic        rsp_wait;
   logic        rsp_free;
   logic        fields_ok;
   logic [39:0] rsp_bus;

   assign req_wait  = req_valid && !req_ready;
   assign rsp_wait  = rsp_valid && !rsp_ready;
   assign rsp_free  = !rsp_valid || rsp_ready;
   assign rsp_bus   = {rsp_year, rsp_month, rsp_day_of_month, rsp_hour, rsp_minute,
                       rsp_second, rsp_weekday};
   assign fields_ok = (rsp_year >= 11'd1970) && (rsp_year <= 11'd2038) &&
                      (rsp_month >= 4'd1) && (rsp_month <= 4'd12) &&
                      (rsp_day_of_month >= 5'd1) && (rsp_hour <= 5'd23) &&
                      (rsp_minute <= 6'd59) && (rsp_second <= 6'd59) &&
                      (rsp_weekday <= 3'd6);

   `ESC_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")
   `ESC_ASSERT(a_ready_drain, clock, reset, rsp_free |-> req_ready, "request refused while draining")
   `ESC_ASSERT(a_fields_in_range, clock, reset, rsp_valid |-> fields_ok, "result field out of range")
   `ESC_ASSERT(a_rsp_held, clock, reset, rsp_wait |=> $stable(rsp_bus), "stalled result moved")
   `ESC_ASSERT(a_req_held, clock, reset, req_wait |=> $stable(req_epoch_seconds), "request moved")

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_esc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_epoch_seconds (req_epoch_seconds),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_year          (rsp_year),
   .rsp_month         (rsp_month),
   .rsp_day_of_month  (rsp_day_of_month),
   .rsp_hour          (rsp_hour),
   .rsp_minute        (rsp_minute),
   .rsp_second        (rsp_second),
   .rsp_weekday       (rsp_weekday)
);

### verif/esc_calendar_checker.sv
// -----------------------------------------------------------------------------
// esc_calendar_checker
// watches both channels of the epoch to calendar core and checks every result
//
// each accepted request is turned into the expected calendar date and kept in
// arrival order; each accepted result is compared field by field with the
// oldest expected date. results with nothing waiting count as mismatches.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_calendar_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [30:0] req_epoch_seconds,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [10:0] rsp_year,
   input  logic [3:0]  rsp_month,
   input  logic [4:0]  rsp_day_of_month,
   input  logic [4:0]  rsp_hour,
   input  logic [5:0]  rsp_minute,
   input  logic [5:0]  rsp_second,
   input  logic [2:0]  rsp_weekday,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count
);

   esc_pkg::esc_date_type expected_dates[$];

   // month_no counts from 0 = january
   function automatic int unsigned days_in_month(input int unsigned month_no,
                                                 input int unsigned year_no);
      unique case (month_no)
         1: begin
            return (year_no % 4 == 0) ? 29 : 28;
         end
         3, 5, 8, 10: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic esc_pkg::esc_date_type calendar_of(input logic [30:0] stamp);
      esc_pkg::esc_date_type d;
      int unsigned secs, days, tod, year_no, month_no, left;
      secs     = {1'b0, stamp};
      days     = secs / 86400;
      tod      = secs % 86400;
      year_no  = 1970;
      month_no = 0;
      left     = days;
      while (left >= ((year_no % 4 == 0) ? 366 : 365)) begin
         left    -= (year_no % 4 == 0) ? 366 : 365;
         year_no += 1;
      end
      while (month_no < 11 && left >= days_in_month(month_no, year_no)) begin
         left     -= days_in_month(month_no, year_no);
         month_no += 1;
      end
      d.year         = 11'(year_no);
      d.month        = 4'(month_no + 1);
      d.day_of_month = 5'(left + 1);
      d.hour         = 5'(tod / 3600);
      d.minute       = 6'((tod % 3600) / 60);
      d.second       = 6'(tod % 60);
      // 1970-01-01 was a thursday
      d.weekday      = 3'((days + 4) % 7);
      return d;
   endfunction

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      esc_pkg::esc_date_type want;
      if (reset) begin
         expected_dates.delete();
         mismatch_count = 0;
         checked_count  = 0;
      end else begin
         if (req_valid && req_ready)
            expected_dates.push_back(calendar_of(req_epoch_seconds));
         if (rsp_valid && rsp_ready) begin
            if (expected_dates.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d",
                        $time, rsp_year, rsp_month, rsp_day_of_month);
            end else begin
               want = expected_dates.pop_front();
               checked_count++;
               check_field("year", 32'(want.year), 32'(rsp_year));
               check_field("month", 32'(want.month), 32'(rsp_month));
               check_field("day_of_month", 32'(want.day_of_month),
                           32'(rsp_day_of_month));
               check_field("hour", 32'(want.hour), 32'(rsp_hour));
               check_field("minute", 32'(want.minute), 32'(rsp_minute));
               check_field("second", 32'(want.second), 32'(rsp_second));
               check_field("weekday", 32'(want.weekday), 32'(rsp_weekday));
            end
         end
      end
      pending_count = expected_dates.size();
   end

endmodule

### verif/tb_epoch_seconds_to_calendar_core.sv
// -----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_core
// stimulus and verdict for the epoch seconds to calendar core
//
// drives corner timestamps (time of day limits, leap days, month and year
// edges, the largest 31-bit value) and then a random mix of uniform stamps,
// stamps near month and day boundaries and stamps near both ends of the range.
// both sides idle at random; the receiver also holds off for a long stretch
// so the pipeline fills. checking is done by esc_calendar_checker.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_core;

   localparam int RANDOM_REQUESTS = 830;
   localparam int HOLD_CYCLES     = 80;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 20;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [30:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [10:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [2:0]  rsp_weekday;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int send_gap_pct = 28;
   int take_gap_pct = 28;
   int hold_asked   = 0;
   int hold_served  = 0;
   int sent_count   = 0;
   int stuck_cycles = 0;

   always #2 clock = ~clock;

   epoch_seconds_to_calendar_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

   esc_calendar_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count)
   );

   // seconds since the epoch for a given calendar date and time
   function automatic longint stamp_of(input int y, input int m, input int d,
                                       input int h, input int mi, input int s);
      longint days;
      days = 0;
      for (int k = 1970; k < y; k++)
         days += (k % 4 == 0) ? 366 : 365;
      for (int k = 1; k < m; k++) begin
         if (k == 2)
            days += (y % 4 == 0) ? 29 : 28;
         else if (k == 4 || k == 6 || k == 9 || k == 11)
            days += 30;
         else
            days += 31;
      end
      days += d - 1;
      return days * 86400 + h * 3600 + mi * 60 + s;
   endfunction

   function automatic logic [30:0] random_stamp();
      longint v;
      int     pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         v = $urandom() & 32'h7FFF_FFFF;
      end else if (pick < 70) begin
         // a few seconds either side of a month start
         v = stamp_of($urandom_range(2037, 1970), $urandom_range(12, 1), 1, 0, 0, 0);
         v = v + $urandom_range(6) - 3;
         if (v < 0)
            v = $urandom_range(3);
      end else if (pick < 85) begin
         v = longint'($urandom_range(24855)) * 86400;
         case ($urandom_range(5))
            0: v += 0;
            1: v += 59;
            2: v += 3600;
            3: v += 86399;
            4: v += 3599;
            default: v += $urandom_range(86399);
         endcase
         if (v > 32'h7FFF_FFFF)
            v -= 86400;
      end else if (pick < 93) begin
         v = $urandom_range(100000);
      end else begin
         v = 32'h7FFF_FFFF - $urandom_range(100000);
      end
      return v[30:0];
   endfunction

   task automatic send_request(input logic [30:0] stamp);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= stamp;
      do
         @(posedge clock);
      while (!req_ready);
      sent_count++;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_count != 0);
      @(posedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= take_gap_pct);
         end
      end
   end

   // watchdog on cycles with no request or result accepted
   initial begin
      while (stuck_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [30:0] corner_stamps[$];
      corner_stamps = '{31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600,
                        31'd86399, 31'd86400};
      corner_stamps.push_back(31'(stamp_of(1970, 12, 31, 23, 59, 59)));
      corner_stamps.push_back(31'(stamp_of(1971, 1, 1, 0, 0, 0)));
      corner_stamps.push_back(31'(stamp_of(1972, 2, 28, 23, 59, 59)));
      corner_stamps.push_back(31'(stamp_of(1972, 2, 29, 12, 30, 30)));
      corner_stamps.push_back(31'(stamp_of(1972, 3, 1, 0, 0, 0)));
      corner_stamps.push_back(31'(stamp_of(1972, 12, 31, 23, 59, 59)));
      corner_stamps.push_back(31'(stamp_of(2000, 2, 29, 0, 0, 0)));
      corner_stamps.push_back(31'(stamp_of(2000, 12, 31, 23, 59, 59)));
      corner_stamps.push_back(31'(stamp_of(2001, 2, 28, 23, 59, 59)));
      corner_stamps.push_back(31'(stamp_of(2001, 3, 1, 0, 0, 0)));
      corner_stamps.push_back(31'(stamp_of(2037, 12, 31, 23, 59, 59)));
      corner_stamps.push_back(31'h7FFF_FFFE);
      corner_stamps.push_back(31'h7FFF_FFFF);
      corner_stamps.push_back(31'h5555_5555);
      corner_stamps.push_back(31'h2AAA_AAAA);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_stamps[i])
         send_request(corner_stamps[i]);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == 250) begin
            send_gap_pct = 0;
            take_gap_pct = 0;
         end else if (i == 400) begin
            send_gap_pct = 28;
            take_gap_pct = 28;
         end else if (i == 500) begin
            // back-pressure: output held off while requests keep coming
            send_gap_pct = 0;
            hold_asked++;
         end else if (i == 540) begin
            send_gap_pct = 28;
            req_valid <= 1'b0;
            wait_drained();
         end
         send_request(random_stamp());
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: time of day limits, leap days, month and year edges",
               sent_count);
      $display("%0d results checked under random stalls and an %0d cycle output hold-off",
               checked_count, HOLD_CYCLES);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
